/* sv/agac_pkg.sv */
// ----------------------------------------------------------------------------
// agac_pkg
// Shared widths, limits, register indexes, cell data types and saturating
// helpers for the affine-gap alignment cost core.
// ----------------------------------------------------------------------------
package agac_pkg;

  // Width of one DP cell value and the saturation limits.
  localparam int unsigned CELL_W = 21;
  localparam int unsigned COST_W = 20;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned REG_W  = 8;
  localparam int unsigned IDX_W  = 2;

  localparam logic [CELL_W-1:0] CELL_CAP = {CELL_W{1'b1}};
  localparam logic [COST_W-1:0] OUT_CAP  = {COST_W{1'b1}};

  // Default capacity of the stored first sequence.
  localparam int unsigned MAX_LEN_DEF = 1024;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MISMATCH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAP_OPEN   = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAP_EXTEND = 2'd2;

  // Configuration reset values.
  localparam logic [REG_W-1:0] MISMATCH_RST   = 8'd4;
  localparam logic [REG_W-1:0] GAP_OPEN_RST   = 8'd10;
  localparam logic [REG_W-1:0] GAP_EXTEND_RST = 8'd1;

  // Operands of one cell update.
  typedef struct packed {
    logic [CELL_W-1:0] up_d;
    logic [CELL_W-1:0] up_p;
    logic [CELL_W-1:0] diag;
    logic [CELL_W-1:0] left_d;
    logic [CELL_W-1:0] left_q;
    logic [SYM_W-1:0]  a_sym;
    logic [SYM_W-1:0]  b_sym;
    logic [REG_W-1:0]  mismatch;
    logic [REG_W-1:0]  gap_open;
    logic [REG_W-1:0]  gap_extend;
  } agac_cell_in_t;

  // Results of one cell update.
  typedef struct packed {
    logic [CELL_W-1:0] d;
    logic [CELL_W-1:0] p;
    logic [CELL_W-1:0] q;
  } agac_cell_out_t;

  // Clamp a sum with one carry bit to the cell range.
  function automatic logic [CELL_W-1:0] sat_cell(input logic [CELL_W:0] v);
    sat_cell = v[CELL_W] ? CELL_CAP : v[CELL_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] min_cell(input logic [CELL_W-1:0] x,
                                                 input logic [CELL_W-1:0] y);
    min_cell = (x < y) ? x : y;
  endfunction

endpackage

/* sv/agac_ram.sv */
// ----------------------------------------------------------------------------
// agac_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module agac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/agac_cell.sv */
// ----------------------------------------------------------------------------
// agac_cell
// Shared cell update unit: computes D, P and Q of one DP cell with
// saturating affine-gap recurrences. Used once per cycle by the row sweep.
// ----------------------------------------------------------------------------
module agac_cell
  import agac_pkg::*;
(
  input  agac_cell_in_t  cin,
  output agac_cell_out_t cout
);

  logic [REG_W:0]    open_ext;
  logic [CELL_W-1:0] p_open;
  logic [CELL_W-1:0] p_ext;
  logic [CELL_W-1:0] q_open;
  logic [CELL_W-1:0] q_ext;
  logic [CELL_W-1:0] p_val;
  logic [CELL_W-1:0] q_val;
  logic [REG_W-1:0]  sub_cost;
  logic [CELL_W-1:0] d_diag;

  always_comb begin
    open_ext = {1'b0, cin.gap_open} + {1'b0, cin.gap_extend};

    // Vertical gap: open from D above or extend P above.
    p_open = sat_cell({1'b0, cin.up_d} + (CELL_W + 1)'(open_ext));
    p_ext  = sat_cell({1'b0, cin.up_p} + (CELL_W + 1)'(cin.gap_extend));
    p_val  = min_cell(p_open, p_ext);

    // Horizontal gap: open from new D on the left or extend Q on the left.
    q_open = sat_cell({1'b0, cin.left_d} + (CELL_W + 1)'(open_ext));
    q_ext  = sat_cell({1'b0, cin.left_q} + (CELL_W + 1)'(cin.gap_extend));
    q_val  = min_cell(q_open, q_ext);

    // Diagonal move: free on a match.
    sub_cost = (cin.a_sym == cin.b_sym) ? '0 : cin.mismatch;
    d_diag   = sat_cell({1'b0, cin.diag} + (CELL_W + 1)'(sub_cost));

    cout.p = p_val;
    cout.q = q_val;
    cout.d = min_cell(d_diag, min_cell(p_val, q_val));
  end

endmodule

/* sv/affine_gap_alignment_cost_core.sv */
// ----------------------------------------------------------------------------
// affine_gap_alignment_cost_core
// Global alignment cost with affine gaps; one DP cell per cycle in row sweeps.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser selects the sequence (0 = A, 1 = B), tdata carries
//   the symbol and tlast closes the sequence. Send all of A first, then B.
//   An A symbol is stored and tready stays high; symbols beyond MAX_LEN are
//   dropped and flagged. A B symbol fills one DP row against stored A, and
//   tready stays low through S_MUL, S_START, the S_ROW column sweep and
//   S_END, so the next B symbol waits for the row, bounded by the single cell
//   unit that works through one column per cycle.
//   Output stream: after the B symbol with tlast, one transfer carries the
//   saturated cost in tdata and the overflow flag in tuser, once the final
//   row has been swept.
//   The result waits in an output register. If the receiver stalls, the
//   next row still runs; the block only holds in its final step while a
//   previous result is still untaken.
//   Configuration writes take effect at once and are to be done while idle;
//   the block does not enforce this. Reset (synchronous) restores register
//   defaults and empties both sequences; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module affine_gap_alignment_cost_core
  import agac_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] symbol
  input  logic              s_axis_tuser,   // [0] mode
  input  logic              s_axis_tlast,
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [19:0] total_cost, [23:20] zero
  output logic              m_axis_tuser,   // [0] overflow
  // Configuration port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned PW = CELL_W + REG_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  // Configuration registers.
  logic [REG_W-1:0] mismatch;
  logic [REG_W-1:0] gap_open;
  logic [REG_W-1:0] gap_extend;

  // Control state.
  logic [2:0]        state;
  logic [CW-1:0]     a_count;
  logic              a_closed;
  logic              overflow_seen;
  logic              row_init;
  logic [CELL_W-1:0] b_count;
  logic [CW-1:0]     col;

  // Row data path registers.
  logic [SYM_W-1:0]  b_sym;
  logic              b_last;
  logic [REG_W-1:0]  init_open;
  logic [REG_W-1:0]  init_extend;
  logic [PW-1:0]     prod;
  logic [CELL_W-1:0] d0;
  logic [CELL_W-1:0] diag;
  logic [CELL_W-1:0] left_d;
  logic [CELL_W-1:0] left_q;
  logic [CELL_W-1:0] run_d;
  logic [CELL_W-1:0] run_p;

  // Memory ports.
  logic              a_we;
  logic [AW-1:0]     rd_addr;
  logic [SYM_W-1:0]  a_rdata;
  logic [CELL_W-1:0] d_rdata;
  logic [CELL_W-1:0] p_rdata;
  logic              row_we;

  agac_cell_in_t     cell_in;
  agac_cell_out_t    cell_out;

  logic              in_xfer;
  logic              out_xfer;
  logic              res_load;
  logic [CW-1:0]     col_inc;
  logic [CELL_W-1:0] b_base;
  logic [PW:0]       d0_sum;
  logic [PW:0]       q0_sum;
  logic [CELL_W-1:0] d0_new;
  logic [CELL_W-1:0] q0_new;
  logic              cost_big;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign res_load      = (state == S_END) && b_last && (!m_axis_tvalid || m_axis_tready);
  assign col_inc       = col + CW'(1);
  assign b_base        = a_closed ? b_count : '0;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch   <= MISMATCH_RST;
      gap_open   <= GAP_OPEN_RST;
      gap_extend <= GAP_EXTEND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MISMATCH:   mismatch   <= cfg_data;
        REG_GAP_OPEN:   gap_open   <= cfg_data;
        REG_GAP_EXTEND: gap_extend <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stored first sequence and the previous DP row (columns 1 and up).
  assign a_we    = in_xfer && !s_axis_tuser && !a_closed && (a_count != CW'(MAX_LEN));
  assign row_we  = (state == S_ROW);
  assign rd_addr = (state == S_ROW) ? col_inc[AW-1:0] : '0;

  agac_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_seq_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_count[AW-1:0]),
    .wdata (s_axis_tdata),
    .raddr (rd_addr),
    .rdata (a_rdata)
  );

  agac_ram #(.WIDTH(CELL_W), .DEPTH(MAX_LEN)) u_d_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (col[AW-1:0]),
    .wdata (cell_out.d),
    .raddr (rd_addr),
    .rdata (d_rdata)
  );

  agac_ram #(.WIDTH(CELL_W), .DEPTH(MAX_LEN)) u_p_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (col[AW-1:0]),
    .wdata (cell_out.p),
    .raddr (rd_addr),
    .rdata (p_rdata)
  );

  // Shared cell unit; the first row after A closes comes from the
  // running initial values instead of the row memories.
  always_comb begin
    cell_in.up_d       = row_init ? run_d : d_rdata;
    cell_in.up_p       = row_init ? run_p : p_rdata;
    cell_in.diag       = diag;
    cell_in.left_d     = left_d;
    cell_in.left_q     = left_q;
    cell_in.a_sym      = a_rdata;
    cell_in.b_sym      = b_sym;
    cell_in.mismatch   = mismatch;
    cell_in.gap_open   = gap_open;
    cell_in.gap_extend = gap_extend;
  end

  agac_cell u_cell (
    .cin  (cell_in),
    .cout (cell_out)
  );

  // Column zero of the new row from the registered row-count product.
  always_comb begin
    d0_sum = (PW + 1)'(prod) + (PW + 1)'(gap_open);
    q0_sum = d0_sum + (PW + 1)'(gap_open);
    d0_new = (d0_sum > (PW + 1)'(CELL_CAP)) ? CELL_CAP : d0_sum[CELL_W-1:0];
    q0_new = (q0_sum > (PW + 1)'(CELL_CAP)) ? CELL_CAP : q0_sum[CELL_W-1:0];
  end

  assign cost_big = (left_d > CELL_W'(OUT_CAP));

  // Sequencer: symbol intake, row setup, column sweep and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      a_count       <= '0;
      a_closed      <= 1'b0;
      overflow_seen <= 1'b0;
      row_init      <= 1'b0;
      b_count       <= '0;
      col           <= '0;
      d0            <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (!s_axis_tuser) begin
              // Symbol of A; ignored once A is closed.
              if (!a_closed) begin
                if (a_count != CW'(MAX_LEN)) begin
                  a_count <= a_count + CW'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
                if (s_axis_tlast) begin
                  a_closed    <= 1'b1;
                  row_init    <= 1'b1;
                  b_count     <= '0;
                  d0          <= '0;
                  init_open   <= gap_open;
                  init_extend <= gap_extend;
                end
              end
            end else begin
              // Symbol of B; closes A first if still open.
              if (!a_closed) begin
                a_closed    <= 1'b1;
                row_init    <= 1'b1;
                d0          <= '0;
                init_open   <= gap_open;
                init_extend <= gap_extend;
              end
              b_count <= (b_base == CELL_CAP) ? b_base : b_base + CELL_W'(1);
              b_sym   <= s_axis_tdata;
              b_last  <= s_axis_tlast;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= PW'(b_count) * PW'(gap_extend);
          state <= S_START;
        end
        S_START: begin
          diag   <= d0;
          d0     <= d0_new;
          left_d <= d0_new;
          left_q <= q0_new;
          run_d  <= CELL_W'({1'b0, init_open} + {1'b0, init_extend});
          run_p  <= CELL_W'({2'b0, init_open} + {2'b0, init_open} + {2'b0, init_extend});
          col    <= '0;
          state  <= (a_count == '0) ? S_END : S_ROW;
        end
        S_ROW: begin
          diag   <= cell_in.up_d;
          left_d <= cell_out.d;
          left_q <= cell_out.q;
          run_d  <= sat_cell({1'b0, run_d} + (CELL_W + 1)'(init_extend));
          run_p  <= sat_cell({1'b0, run_p} + (CELL_W + 1)'(init_extend));
          col    <= col_inc;
          if (col_inc == a_count) begin
            state <= S_END;
          end
        end
        S_END: begin
          if (!b_last) begin
            row_init <= 1'b0;
            state    <= S_IDLE;
          end else if (!m_axis_tvalid || m_axis_tready) begin
            row_init      <= 1'b0;
            a_count       <= '0;
            a_closed      <= 1'b0;
            overflow_seen <= 1'b0;
            b_count       <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result valid: set when a result is loaded, cleared by its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (out_xfer) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result register, loaded when the final row completes.
  always_ff @(posedge clk) begin
    if (res_load) begin
      m_axis_tdata <= {4'b0, (cost_big ? OUT_CAP : left_d[COST_W-1:0])};
      m_axis_tuser <= overflow_seen || cost_big;
    end
  end

endmodule
